/* sv/fsis_pkg.sv */
package fsis_pkg;

  localparam int MAX_ITEMS_DEF = 1024;
  localparam int VALUE_W       = 32;
  localparam int TARGET_W      = 34;
  localparam int INDEX_W       = 11;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] first_index;
    logic [INDEX_W-1:0] second_index;
    logic [INDEX_W-1:0] third_index;
    logic [INDEX_W-1:0] fourth_index;
    logic               overflow;
  } out_item_t;

endpackage

/* sv/fsis_ram.sv */
module fsis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/four_sum_index_search.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall | fsis_pkg::in_item_t
// out     | output    | out_valid, out_stall | fsis_pkg::out_item_t
// cfg     | input     | cfg_we             | cfg_wdata (target sum)
// A value is taken every cycle while a set loads into the item memory.
// After the last item the set is insertion-sorted by value and then searched
// with two outer indices and two inner pointers that move towards each other,
// all bound by the single read port of the item memory.
// The input is stalled from the last item until the result is registered.
// Reset (rst_n low, synchronous) empties the set and clears the target.
module four_sum_index_search #(
  parameter int MAX_ITEMS = fsis_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fsis_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fsis_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [fsis_pkg::TARGET_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = CW + 3;
  localparam int VW = fsis_pkg::VALUE_W;
  localparam int TW = fsis_pkg::TARGET_W;
  localparam int IW = fsis_pkg::INDEX_W;

  typedef struct packed {
    logic [VW-1:0] value;
    logic [AW-1:0] pos;
  } entry_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_SORT_NEXT, ST_SORT_RD, ST_SORT_KEY, ST_SORT_CMP, ST_SORT_PUT,
    ST_SRCH_START, ST_SRCH_I, ST_SRCH_IW, ST_SRCH_J, ST_SRCH_JW, ST_SRCH_LW,
    ST_SRCH_HW, ST_SRCH_CMP, ST_SRCH_LO, ST_SRCH_HI, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                drop_r, drop_nxt;
  logic [TW-1:0]       tgt_r;
  logic                out_valid_r, out_valid_nxt;
  fsis_pkg::out_item_t out_item_r, out_item_nxt;
  logic [CW-1:0]       a_r, a_nxt, b_r, b_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  entry_t              key_r, key_nxt, ei_r, ei_nxt, ej_r, ej_nxt;
  entry_t              elo_r, elo_nxt, ehi_r, ehi_nxt;
  logic [VW:0]         pij_r, pij_nxt;
  fsis_pkg::out_item_t res_r, res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  logic                in_xfer;
  logic [TW-1:0]       quad_sum;

  fsis_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != ST_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign quad_sum  = TW'(pij_r) + TW'(elo_r.value) + TW'(ehi_r.value);

  function automatic logic [IW-1:0] to_index(input logic [AW-1:0] pos);
    logic [CW-1:0] p1;
    p1 = CW'(pos) + CW'(1);
    return IW'(p1);
  endfunction

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    key_nxt = key_r;
    ei_nxt  = ei_r;
    ej_nxt  = ej_r;
    elo_nxt = elo_r;
    ehi_nxt = ehi_r;
    pij_nxt = pij_r;
    res_nxt = res_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_r;
    ram_raddr = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (XW'(cnt_r) < XW'(MAX_ITEMS)) begin
            ram_we          = 1'b1;
            ram_waddr       = cnt_r[AW-1:0];
            ram_wdata.value = in_item.value;
            ram_wdata.pos   = cnt_r[AW-1:0];
            cnt_nxt         = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_item.last) begin
            a_nxt     = CW'(1);
            state_nxt = ST_SORT_NEXT;
          end
        end
      end
      ST_SORT_NEXT: begin
        state_nxt = (a_r < cnt_r) ? ST_SORT_RD : ST_SRCH_START;
      end
      ST_SORT_RD: begin
        ram_raddr = a_r[AW-1:0];
        state_nxt = ST_SORT_KEY;
      end
      ST_SORT_KEY: begin
        key_nxt   = ram_rdata;
        b_nxt     = a_r;
        ram_raddr = AW'(a_r - CW'(1));
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = b_r[AW-1:0];
        if (ram_rdata.value > key_r.value) begin
          ram_wdata = ram_rdata;
          b_nxt     = b_r - CW'(1);
          if (b_r == CW'(1)) begin
            state_nxt = ST_SORT_PUT;
          end else begin
            ram_raddr = AW'(b_r - CW'(2));
          end
        end else begin
          ram_wdata = key_r;
          a_nxt     = a_r + CW'(1);
          state_nxt = ST_SORT_NEXT;
        end
      end
      ST_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = b_r[AW-1:0];
        ram_wdata = key_r;
        a_nxt     = a_r + CW'(1);
        state_nxt = ST_SORT_NEXT;
      end
      ST_SRCH_START: begin
        res_nxt = '0;
        i_nxt   = '0;
        state_nxt = (XW'(cnt_r) < XW'(4)) ? ST_DONE : ST_SRCH_I;
      end
      ST_SRCH_I: begin
        ram_raddr = i_r[AW-1:0];
        state_nxt = ST_SRCH_IW;
      end
      ST_SRCH_IW: begin
        ei_nxt    = ram_rdata;
        j_nxt     = i_r + CW'(1);
        state_nxt = ST_SRCH_J;
      end
      ST_SRCH_J: begin
        ram_raddr = j_r[AW-1:0];
        state_nxt = ST_SRCH_JW;
      end
      ST_SRCH_JW: begin
        ej_nxt    = ram_rdata;
        pij_nxt   = (VW+1)'(ei_r.value) + (VW+1)'(ram_rdata.value);
        lo_nxt    = j_r + CW'(1);
        hi_nxt    = cnt_r - CW'(1);
        ram_raddr = AW'(j_r + CW'(1));
        state_nxt = ST_SRCH_LW;
      end
      ST_SRCH_LW: begin
        elo_nxt   = ram_rdata;
        ram_raddr = hi_r[AW-1:0];
        state_nxt = ST_SRCH_HW;
      end
      ST_SRCH_HW: begin
        ehi_nxt   = ram_rdata;
        state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (quad_sum == tgt_r) begin
          res_nxt.found        = 1'b1;
          res_nxt.first_index  = to_index(ei_r.pos);
          res_nxt.second_index = to_index(ej_r.pos);
          res_nxt.third_index  = to_index(elo_r.pos);
          res_nxt.fourth_index = to_index(ehi_r.pos);
          state_nxt = ST_DONE;
        end else if (XW'(lo_r) + XW'(1) < XW'(hi_r)) begin
          if (quad_sum < tgt_r) begin
            lo_nxt    = lo_r + CW'(1);
            ram_raddr = AW'(lo_r + CW'(1));
            state_nxt = ST_SRCH_LO;
          end else begin
            hi_nxt    = hi_r - CW'(1);
            ram_raddr = AW'(hi_r - CW'(1));
            state_nxt = ST_SRCH_HI;
          end
        end else if (XW'(j_r) + XW'(3) < XW'(cnt_r)) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_SRCH_J;
        end else if (XW'(i_r) + XW'(4) < XW'(cnt_r)) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SRCH_I;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SRCH_LO: begin
        elo_nxt   = ram_rdata;
        state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_HI: begin
        ehi_nxt   = ram_rdata;
        state_nxt = ST_SRCH_CMP;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt          = res_r;
          out_item_nxt.overflow = drop_r;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tgt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    key_r <= key_nxt;
    ei_r  <= ei_nxt;
    ej_r  <= ej_nxt;
    elo_r <= elo_nxt;
    ehi_r <= ehi_nxt;
    pij_r <= pij_nxt;
    res_r <= res_nxt;
  end

endmodule
